FILE: rtl/core/arsa_pkg.sv
`default_nettype none
package arsa_pkg;

  localparam int MAX_SEG   = 64;
  localparam int IDX_BITS  = $clog2(MAX_SEG);
  localparam int CNT_BITS  = IDX_BITS + 1;
  localparam int PAGE_BITS = 36;
  localparam int SIZE_BITS = PAGE_BITS + 1;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [SIZE_BITS-1:0] size_t;
  typedef logic [IDX_BITS-1:0]  idx_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  localparam size_t RESET_RANGE_PAGES = SIZE_BITS'(1048576);

  localparam logic [1:0] OP_ALLOC    = 2'd0;
  localparam logic [1:0] OP_ALLOC_AT = 2'd1;
  localparam logic [1:0] OP_FREE     = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NOFIT    = 2'd1;
  localparam logic [1:0] STAT_NOTFOUND = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  localparam logic [2:0] PROT_NOACCESS = 3'd0;

  localparam logic CFG_RANGE_BASE  = 1'b0;
  localparam logic CFG_RANGE_PAGES = 1'b1;

  typedef struct packed {
    page_t      base;
    size_t      len;
    logic       used;
    logic [2:0] prot;
  } seg_t;

  typedef struct packed {
    page_t addr;
    size_t size;
  } query_t;

  typedef struct packed {
    logic fit;
    logic contain;
    logic baseeq;
  } flags_t;

  // writes land at idx..idx+shift, cells above move up by shift
  typedef struct packed {
    logic       apply;
    idx_t       idx;
    logic [1:0] shift;
    seg_t       w0;
    seg_t       w1;
    seg_t       w2;
  } cell_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/arsa_in_if.sv
`default_nettype none
interface arsa_in_if;
  import arsa_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  page_t      address_page;
  size_t      size_pages;
  logic [2:0] protection;

  modport source (output valid, operation, address_page, size_pages, protection,
                  input ready);
  modport sink (input valid, operation, address_page, size_pages, protection,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/core/arsa_out_if.sv
`default_nettype none
interface arsa_out_if;
  import arsa_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  page_t      segment_base_page;
  size_t      segment_pages;
  size_t      pages_in_use;

  modport source (output valid, status, segment_base_page, segment_pages, pages_in_use,
                  input ready);
  modport sink (input valid, status, segment_base_page, segment_pages, pages_in_use,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/core/arsa_cell.sv
`default_nettype none
module arsa_cell (
  input  logic                  clk,
  input  arsa_pkg::idx_t        cell_idx,
  input  logic                  load,
  input  arsa_pkg::seg_t        load_seg,
  input  arsa_pkg::cell_cmd_t   cmd,
  input  arsa_pkg::seg_t        prev1,
  input  arsa_pkg::seg_t        prev2,
  input  arsa_pkg::query_t      query,
  output arsa_pkg::seg_t        seg,
  output arsa_pkg::flags_t      flags
);
  import arsa_pkg::*;

  seg_t  seg_r, seg_nxt;
  idx_t  rel_idx;
  logic  at_or_above;
  page_t off;

  always_comb begin
    rel_idx     = cell_idx - cmd.idx;
    at_or_above = cell_idx >= cmd.idx;
    seg_nxt     = seg_r;
    if (load) begin
      seg_nxt = load_seg;
    end else if (cmd.apply && at_or_above) begin
      if (int'(rel_idx) <= int'(cmd.shift)) begin
        if (int'(rel_idx) == 0) begin
          seg_nxt = cmd.w0;
        end else if (int'(rel_idx) == 1) begin
          seg_nxt = cmd.w1;
        end else begin
          seg_nxt = cmd.w2;
        end
      end else if (cmd.shift == 2'd2) begin
        seg_nxt = prev2;
      end else if (cmd.shift == 2'd1) begin
        seg_nxt = prev1;
      end
    end
  end

  always_ff @(posedge clk) begin
    seg_r <= seg_nxt;
  end

  always_comb begin
    off           = query.addr - seg_r.base;
    flags.fit     = !seg_r.used && (seg_r.len >= query.size);
    flags.contain = (query.addr >= seg_r.base) && ({1'b0, off} < seg_r.len);
    flags.baseeq  = seg_r.base == query.addr;
  end

  assign seg = seg_r;

endmodule
`default_nettype wire

FILE: rtl/core/arsa_pick.sv
`default_nettype none
module arsa_pick (
  input  logic [arsa_pkg::MAX_SEG-1:0] req,
  input  arsa_pkg::seg_t               segs [arsa_pkg::MAX_SEG],
  output logic                         found,
  output arsa_pkg::idx_t               idx,
  output arsa_pkg::seg_t               seg
);
  import arsa_pkg::*;

  logic [MAX_SEG-1:0] first;

  // lowest set request wins
  always_comb begin
    first = req & (~req + 1'b1);
    found = |req;
    idx   = '0;
    seg   = '0;
    for (int j = 0; j < MAX_SEG; j++) begin
      if (first[j]) begin
        idx = idx | IDX_BITS'(j);
        seg = seg | segs[j];
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/address_range_segment_allocator.sv
`default_nettype none
// First-fit page range allocator. A row of 64 segment cells holds an address-ordered
// table covering the configured range; every cell compares its own segment with the
// request in parallel, a priority pick selects the first hit, and the update shifts the
// cells above it up by zero to two places in one step while writing the new segments.
// A result appears once its item has passed the compare, pick, decide and update steps,
// one item at a time; the next item can be accepted in the same cycle as the result
// appears. The result waits in an output register while the next item is taken; that
// item's update holds until the output register is free. After reset or any
// configuration write the table is rebuilt from the configured range, and no item is
// accepted while that happens.
module address_range_segment_allocator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  arsa_pkg::size_t     cfg_wdata,
  arsa_in_if.sink             in_if,
  arsa_out_if.source          out_if
);
  import arsa_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CMP   = 3'd1;
  localparam logic [2:0] ST_PICK  = 3'd2;
  localparam logic [2:0] ST_EXEC  = 3'd3;
  localparam logic [2:0] ST_APPLY = 3'd4;

  logic [2:0] state_r;
  logic       rebuild_r;
  page_t      range_base_r;
  size_t      range_pages_r;
  cnt_t       count_r;
  size_t      usage_r;

  logic [1:0] op_r;
  page_t      addr_r;
  size_t      size_r;
  logic [2:0] prot_r;

  logic [MAX_SEG-1:0] sel_v_r;
  logic       found_r;
  idx_t       pidx_r;
  seg_t       pseg_r;

  logic [1:0] status_r;
  cell_cmd_t  cmd_r;
  page_t      res_base_r;
  size_t      res_len_r;
  size_t      use_pend_r;
  cnt_t       cnt_pend_r;

  logic       out_valid_r;
  logic [1:0] out_status_r;
  page_t      out_base_r;
  size_t      out_len_r;
  size_t      out_use_r;

  seg_t       segs [MAX_SEG];
  flags_t     flags [MAX_SEG];
  logic [MAX_SEG-1:0] hit_v;
  query_t     query;
  cell_cmd_t  cell_cmd;
  seg_t       init_seg;
  size_t      room;

  logic       in_acc;
  logic       can_out;
  logic       pick_found;
  idx_t       pick_idx;
  seg_t       pick_seg;

  assign in_if.ready = (state_r == ST_IDLE) && !rebuild_r;
  assign in_acc      = in_if.valid && in_if.ready;
  assign can_out     = !out_valid_r || out_if.ready;

  // range clipped at the end of the page space
  always_comb begin
    room          = {1'b1, {PAGE_BITS{1'b0}}} - {1'b0, range_base_r};
    init_seg.base = range_base_r;
    init_seg.len  = (range_pages_r > room) ? room : range_pages_r;
    init_seg.used = 1'b0;
    init_seg.prot = PROT_NOACCESS;
  end

  assign query.addr = addr_r;
  assign query.size = size_r;

  always_comb begin
    cell_cmd       = cmd_r;
    cell_cmd.apply = cmd_r.apply && (state_r == ST_APPLY) && can_out;
  end

  for (genvar g = 0; g < MAX_SEG; g++) begin : g_cell
    seg_t p1, p2;
    if (g >= 1) begin : g_p1
      assign p1 = segs[g-1];
    end else begin : g_p1z
      assign p1 = '0;
    end
    if (g >= 2) begin : g_p2
      assign p2 = segs[g-2];
    end else begin : g_p2z
      assign p2 = '0;
    end
    arsa_cell u_cell (
      .clk      (clk),
      .cell_idx (IDX_BITS'(g)),
      .load     (rebuild_r),
      .load_seg ((g == 0) ? init_seg : '0),
      .cmd      (cell_cmd),
      .prev1    (p1),
      .prev2    (p2),
      .query    (query),
      .seg      (segs[g]),
      .flags    (flags[g])
    );
    always_comb begin
      if (CNT_BITS'(g) >= count_r) begin
        hit_v[g] = 1'b0;
      end else begin
        case (op_r)
          OP_ALLOC:    hit_v[g] = flags[g].fit;
          OP_ALLOC_AT: hit_v[g] = flags[g].contain;
          default:     hit_v[g] = flags[g].baseeq;
        endcase
      end
    end
  end

  arsa_pick u_pick (
    .req   (sel_v_r),
    .segs  (segs),
    .found (pick_found),
    .idx   (pick_idx),
    .seg   (pick_seg)
  );

  // decision on the picked segment
  logic [PAGE_BITS+1:0] seg_end, req_end;
  page_t      off;
  logic       has_pre, after;
  logic [1:0] need;
  logic [CNT_BITS:0] cnt_plus;
  logic [1:0] st_nxt;
  cell_cmd_t  cmd_nxt;
  page_t      rb_nxt;
  size_t      rl_nxt;
  size_t      use_nxt;
  cnt_t       cnt_nxt;
  seg_t       w_main, w_pre, w_post;

  always_comb begin
    seg_end  = (PAGE_BITS+2)'(pseg_r.base) + (PAGE_BITS+2)'(pseg_r.len);
    req_end  = (PAGE_BITS+2)'(addr_r) + (PAGE_BITS+2)'(size_r);
    off      = addr_r - pseg_r.base;
    has_pre  = pseg_r.base < addr_r;
    after    = seg_end > req_end;
    need     = {1'b0, has_pre} + {1'b0, after};
    cnt_plus = (CNT_BITS+1)'(count_r) + (CNT_BITS+1)'(need);

    w_main = '{base: addr_r, len: size_r, used: 1'b1, prot: prot_r};
    w_pre  = '{base: pseg_r.base, len: {1'b0, off}, used: 1'b0, prot: PROT_NOACCESS};
    w_post = '{base: req_end[PAGE_BITS-1:0],
               len: SIZE_BITS'(seg_end - req_end), used: 1'b0, prot: PROT_NOACCESS};

    st_nxt  = STAT_NOFIT;
    cmd_nxt = '0;
    cmd_nxt.idx = pidx_r;
    rb_nxt  = '0;
    rl_nxt  = '0;
    use_nxt = usage_r;
    cnt_nxt = count_r;

    case (op_r)
      OP_ALLOC: begin
        if (size_r != '0 && found_r) begin
          if (pseg_r.len != size_r) begin
            if (count_r >= CNT_BITS'(MAX_SEG)) begin
              st_nxt = STAT_FULL;
            end else begin
              st_nxt        = STAT_OK;
              cmd_nxt.apply = 1'b1;
              cmd_nxt.shift = 2'd1;
              cmd_nxt.w0 = '{base: pseg_r.base, len: size_r, used: 1'b1, prot: prot_r};
              cmd_nxt.w1 = '{base: PAGE_BITS'(pseg_r.base + size_r[PAGE_BITS-1:0]),
                             len: pseg_r.len - size_r, used: 1'b0, prot: PROT_NOACCESS};
              cnt_nxt = count_r + 1'b1;
            end
          end else begin
            st_nxt        = STAT_OK;
            cmd_nxt.apply = 1'b1;
            cmd_nxt.w0    = '{base: pseg_r.base, len: size_r, used: 1'b1, prot: prot_r};
          end
          if (st_nxt == STAT_OK) begin
            use_nxt = usage_r + size_r;
            rb_nxt  = pseg_r.base;
            rl_nxt  = size_r;
          end
        end
      end
      OP_ALLOC_AT: begin
        if (size_r == '0) begin
          st_nxt = STAT_NOFIT;
        end else if (!found_r) begin
          st_nxt = STAT_NOTFOUND;
        end else if (pseg_r.used || ((pseg_r.len - {1'b0, off}) < size_r)) begin
          st_nxt = STAT_NOFIT;
        end else if (cnt_plus > (CNT_BITS+1)'(MAX_SEG)) begin
          st_nxt = STAT_FULL;
        end else begin
          st_nxt        = STAT_OK;
          cmd_nxt.apply = 1'b1;
          cmd_nxt.shift = need;
          if (has_pre) begin
            cmd_nxt.w0 = w_pre;
            cmd_nxt.w1 = w_main;
            cmd_nxt.w2 = w_post;
          end else begin
            cmd_nxt.w0 = w_main;
            cmd_nxt.w1 = w_post;
          end
          cnt_nxt = cnt_plus[CNT_BITS-1:0];
          use_nxt = usage_r + size_r;
          rb_nxt  = addr_r;
          rl_nxt  = size_r;
        end
      end
      OP_FREE: begin
        if (!found_r) begin
          st_nxt = STAT_NOTFOUND;
        end else begin
          st_nxt        = STAT_OK;
          cmd_nxt.apply = 1'b1;
          cmd_nxt.w0    = '{base: pseg_r.base, len: pseg_r.len, used: 1'b0,
                            prot: PROT_NOACCESS};
          if (pseg_r.used) begin
            use_nxt = usage_r - pseg_r.len;
          end
          rb_nxt = pseg_r.base;
          rl_nxt = pseg_r.len;
        end
      end
      default: begin
        st_nxt = STAT_NOFIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      rebuild_r     <= 1'b1;
      range_base_r  <= '0;
      range_pages_r <= RESET_RANGE_PAGES;
      count_r       <= CNT_BITS'(1);
      usage_r       <= '0;
      out_valid_r   <= 1'b0;
      cmd_r         <= '0;
    end else begin
      rebuild_r <= cfg_we;
      if (cfg_we) begin
        case (cfg_index)
          CFG_RANGE_BASE:  range_base_r  <= cfg_wdata[PAGE_BITS-1:0];
          CFG_RANGE_PAGES: range_pages_r <= cfg_wdata;
          default:         range_base_r  <= range_base_r;
        endcase
      end
      if (rebuild_r) begin
        count_r <= CNT_BITS'(1);
        usage_r <= '0;
      end
      if (state_r == ST_APPLY && can_out) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_CMP;
          end
        end
        ST_CMP: begin
          state_r <= ST_PICK;
        end
        ST_PICK: begin
          state_r <= ST_EXEC;
        end
        ST_EXEC: begin
          cmd_r   <= cmd_nxt;
          state_r <= ST_APPLY;
        end
        ST_APPLY: begin
          if (can_out) begin
            count_r <= cnt_pend_r;
            usage_r <= use_pend_r;
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_if.operation;
      addr_r <= in_if.address_page;
      size_r <= in_if.size_pages;
      prot_r <= in_if.protection;
    end
    if (state_r == ST_CMP) begin
      sel_v_r <= hit_v;
    end
    if (state_r == ST_PICK) begin
      found_r <= pick_found;
      pidx_r  <= pick_idx;
      pseg_r  <= pick_seg;
    end
    if (state_r == ST_EXEC) begin
      status_r   <= st_nxt;
      res_base_r <= rb_nxt;
      res_len_r  <= rl_nxt;
      use_pend_r <= use_nxt;
      cnt_pend_r <= cnt_nxt;
    end
    if (state_r == ST_APPLY && can_out) begin
      out_status_r <= status_r;
      out_base_r   <= res_base_r;
      out_len_r    <= res_len_r;
      out_use_r    <= use_pend_r;
    end
  end

  assign out_if.valid             = out_valid_r;
  assign out_if.status            = out_status_r;
  assign out_if.segment_base_page = out_base_r;
  assign out_if.segment_pages     = out_len_r;
  assign out_if.pages_in_use      = out_use_r;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CNT_BITS'(1) && count_r <= CNT_BITS'(MAX_SEG))
    else $error("segment count out of range");

  a_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
    rebuild_r |=> count_r == CNT_BITS'(1) && usage_r == '0)
    else $error("rebuild did not reset table");

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_CMP)
    else $error("accepted item not started");

  a_apply_once: assert property (@(posedge clk) disable iff (!rst_n)
    cell_cmd.apply |=> state_r == ST_IDLE && out_valid_r)
    else $error("table update without result");
`endif

endmodule
`default_nettype wire

FILE: verif/address_range_segment_allocator_test.sv
`default_nettype none
module address_range_segment_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import arsa_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [63:0] PAGE_SPACE = 64'd1 << PAGE_BITS;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [1:0] op;
    page_t      addr;
    size_t      size;
    logic [2:0] prot;
  } request_t;

  typedef struct {
    logic [1:0] status;
    page_t      base;
    size_t      pages;
    size_t      in_use;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  size_t cfg_wdata = '0;

  arsa_in_if  in_if ();
  arsa_out_if out_if ();

  address_range_segment_allocator u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_if    (in_if.sink),
    .out_if   (out_if.source)
  );

  always #6 clk = ~clk;

  // shadow of the segment table
  page_t      range_base;
  size_t      range_len;
  page_t      seg_base [MAX_SEG];
  size_t      seg_len  [MAX_SEG];
  logic       seg_used [MAX_SEG];
  logic [2:0] seg_prot [MAX_SEG];
  int         seg_count;
  size_t      usage;

  request_t pending_items[$];
  grant_t   grants_due[$];
  int       failures = 0;
  int       cycles = 0;
  int       status_seen[4] = '{0, 0, 0, 0};
  bit       steady = 1'b0;
  bit       in_took = 1'b0;
  bit       out_took = 1'b0;
  int       in_gap = 0;
  int       out_wait = 0;

  function automatic void rebuild_table();
    logic [63:0] room;
    logic [63:0] len;
    room = PAGE_SPACE - 64'(range_base);
    len = 64'(range_len);
    if (len > room) len = room;
    for (int i = 0; i < MAX_SEG; i++) begin
      seg_base[i] = '0;
      seg_len[i] = '0;
      seg_used[i] = 1'b0;
      seg_prot[i] = PROT_NOACCESS;
    end
    seg_base[0] = range_base;
    seg_len[0] = size_t'(len);
    seg_count = 1;
    usage = '0;
  endfunction

  function automatic void open_slot(int pos);
    for (int j = seg_count; j > pos; j--) begin
      seg_base[j] = seg_base[j-1];
      seg_len[j] = seg_len[j-1];
      seg_used[j] = seg_used[j-1];
      seg_prot[j] = seg_prot[j-1];
    end
    seg_count++;
  endfunction

  function automatic void set_slot(int pos, logic [63:0] b, logic [63:0] l, logic u,
                                   logic [2:0] p);
    seg_base[pos] = page_t'(b);
    seg_len[pos] = size_t'(l);
    seg_used[pos] = u;
    seg_prot[pos] = p;
  endfunction

  function automatic grant_t serve_request(request_t r);
    grant_t g;
    int slot;
    int hit;
    int need;
    logic [63:0] a, sz, b, e, off;
    g.status = STAT_NOFIT;
    slot = -1;
    hit = -1;
    a = 64'(r.addr);
    sz = 64'(r.size);
    case (r.op)
      OP_ALLOC: begin
        if (sz != 0) begin
          for (int i = 0; i < seg_count && hit < 0; i++)
            if (!seg_used[i] && 64'(seg_len[i]) >= sz) hit = i;
        end
        if (hit >= 0) begin
          if (64'(seg_len[hit]) != sz && seg_count >= MAX_SEG) begin
            g.status = STAT_FULL;
          end else begin
            if (64'(seg_len[hit]) != sz) begin
              b = 64'(seg_base[hit]);
              e = 64'(seg_len[hit]) - sz;
              open_slot(hit);
              set_slot(hit + 1, b + sz, e, 1'b0, PROT_NOACCESS);
              seg_len[hit] = size_t'(sz);
            end
            seg_used[hit] = 1'b1;
            seg_prot[hit] = r.prot;
            usage = usage + size_t'(sz);
            g.status = STAT_OK;
            slot = hit;
          end
        end
      end
      OP_ALLOC_AT: begin
        if (sz != 0) begin
          for (int i = 0; i < seg_count && hit < 0; i++)
            if (a >= 64'(seg_base[i]) && a - 64'(seg_base[i]) < 64'(seg_len[i])) hit = i;
          if (hit < 0) begin
            g.status = STAT_NOTFOUND;
          end else if (!seg_used[hit]) begin
            b = 64'(seg_base[hit]);
            e = b + 64'(seg_len[hit]);
            off = a - b;
            if (64'(seg_len[hit]) - off >= sz) begin
              need = (b < a ? 1 : 0) + (e > a + sz ? 1 : 0);
              if (seg_count + need > MAX_SEG) begin
                g.status = STAT_FULL;
              end else begin
                if (b < a) begin
                  open_slot(hit);
                  set_slot(hit, b, off, 1'b0, PROT_NOACCESS);
                  hit++;
                end
                if (e > a + sz) begin
                  open_slot(hit + 1);
                  set_slot(hit + 1, a + sz, e - (a + sz), 1'b0, PROT_NOACCESS);
                end
                set_slot(hit, a, sz, 1'b1, r.prot);
                usage = usage + size_t'(sz);
                g.status = STAT_OK;
                slot = hit;
              end
            end
          end
        end
      end
      OP_FREE: begin
        for (int i = 0; i < seg_count && hit < 0; i++)
          if (seg_base[i] == r.addr) hit = i;
        if (hit < 0) begin
          g.status = STAT_NOTFOUND;
        end else begin
          // a second free leaves the usage alone
          if (seg_used[hit]) begin
            seg_used[hit] = 1'b0;
            usage = usage - seg_len[hit];
          end
          seg_prot[hit] = PROT_NOACCESS;
          g.status = STAT_OK;
          slot = hit;
        end
      end
      default: g.status = STAT_NOFIT;
    endcase
    g.base = (slot >= 0) ? seg_base[slot] : '0;
    g.pages = (slot >= 0) ? seg_len[slot] : '0;
    g.in_use = usage;
    return g;
  endfunction

  // sender: valid held until the item is taken, then a random gap
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_if.valid && !in_took) begin
      end else if (in_gap != 0) begin
        in_if.valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_items.size() > 0) begin
        request_t r;
        r = pending_items.pop_front();
        in_if.valid <= 1'b1;
        in_if.operation <= r.op;
        in_if.address_page <= r.addr;
        in_if.size_pages <= r.size;
        in_if.protection <= r.prot;
        in_gap <= steady ? 0 : $urandom_range(0, 3);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver stalls, one draw per item taken
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_took) begin
        out_wait = steady ? 0 : $urandom_range(0, 3);
      end else if (out_wait != 0) begin
        out_wait = out_wait - 1;
      end
      out_if.ready <= (out_wait == 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    in_took <= rst_n && in_if.valid && in_if.ready;
    out_took <= rst_n && out_if.valid && out_if.ready;
    if (rst_n && in_if.valid && in_if.ready) begin
      request_t r;
      r.op = in_if.operation;
      r.addr = in_if.address_page;
      r.size = in_if.size_pages;
      r.prot = in_if.protection;
      grants_due.push_back(serve_request(r));
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (grants_due.size() == 0) begin
        $error("result with nothing expected: status %0d", out_if.status);
        failures++;
      end else begin
        grant_t g;
        g = grants_due.pop_front();
        status_seen[g.status]++;
        if (out_if.status !== g.status) begin
          $error("status: expected %0d, got %0d", g.status, out_if.status);
          failures++;
        end
        if (out_if.segment_base_page !== g.base) begin
          $error("segment_base_page: expected %0h, got %0h", g.base,
                 out_if.segment_base_page);
          failures++;
        end
        if (out_if.segment_pages !== g.pages) begin
          $error("segment_pages: expected %0h, got %0h", g.pages, out_if.segment_pages);
          failures++;
        end
        if (out_if.pages_in_use !== g.in_use) begin
          $error("pages_in_use: expected %0h, got %0h", g.in_use, out_if.pages_in_use);
          failures++;
        end
      end
    end
  end

  task automatic push_item(logic [1:0] op, logic [63:0] addr, logic [63:0] size,
                           logic [2:0] prot);
    request_t r;
    r.op = op;
    r.addr = page_t'(addr);
    r.size = size_t'(size);
    r.prot = prot;
    pending_items.push_back(r);
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || grants_due.size() > 0 || in_if.valid)
      @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_range(logic [63:0] b, logic [63:0] l);
    cfg_we <= 1'b1;
    cfg_index <= CFG_RANGE_BASE;
    cfg_wdata <= size_t'(b);
    @(negedge clk);
    cfg_index <= CFG_RANGE_PAGES;
    cfg_wdata <= size_t'(l);
    @(negedge clk);
    cfg_we <= 1'b0;
    range_base = page_t'(b);
    range_len = size_t'(l);
    rebuild_table();
    @(negedge clk);
  endtask

  function automatic logic [63:0] wide_random();
    return {$urandom, $urandom};
  endfunction

  task automatic push_random();
    int pick;
    int k;
    logic [63:0] a, s;
    pick = $urandom_range(0, 99);
    k = $urandom_range(0, 99);
    if (k < 70) s = 64'($urandom_range(1, 8));
    else if (k < 85) s = 64'($urandom_range(1, 64));
    else if (k < 95) s = wide_random();
    else s = 0;
    k = $urandom_range(0, 99);
    if (k < 60) a = 64'(seg_base[$urandom_range(0, seg_count - 1)]) + $urandom_range(0, 3);
    else if (k < 90) a = 64'(range_base) + $urandom_range(0, 300);
    else a = wide_random();
    if (pick < 35) push_item(OP_ALLOC, a, s, 3'($urandom));
    else if (pick < 65) push_item(OP_ALLOC_AT, a, s, 3'($urandom));
    else if (pick < 95) begin
      if ($urandom_range(0, 99) < 85) a = 64'(seg_base[$urandom_range(0, seg_count - 1)]);
      push_item(OP_FREE, a, s, 3'($urandom));
    end else push_item(OP_UNUSED, a, s, 3'($urandom));
  endtask

  initial begin
    logic [63:0] phase_base [7];
    logic [63:0] phase_len  [7];
    in_if.valid = 1'b0;
    in_if.operation = OP_ALLOC;
    in_if.address_page = '0;
    in_if.size_pages = '0;
    in_if.protection = PROT_NOACCESS;
    out_if.ready = 1'b0;
    range_base = '0;
    range_len = RESET_RANGE_PAGES;
    rebuild_table();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: edges of every operation on the reset range
    push_item(OP_ALLOC, 0, 0, 3'd7);
    push_item(OP_ALLOC_AT, 5, 0, 3'd1);
    push_item(OP_UNUSED, PAGE_SPACE - 1, 2 * PAGE_SPACE - 1, 3'd7);
    push_item(OP_ALLOC, 0, 1, 3'd7);
    push_item(OP_ALLOC, 0, PAGE_SPACE, 3'd2);
    push_item(OP_ALLOC_AT, 100, 10, 3'd5);
    push_item(OP_ALLOC_AT, 105, 1, 3'd3);
    push_item(OP_ALLOC_AT, 64'd1 << 20, 1, 3'd3);
    push_item(OP_ALLOC_AT, PAGE_SPACE - 1, 1, 3'd3);
    push_item(OP_ALLOC_AT, 200, 64'd1 << 20, 3'd3);
    push_item(OP_FREE, 100, 0, 3'd0);
    push_item(OP_FREE, 100, 0, 3'd0);
    push_item(OP_FREE, 12345, 0, 3'd0);
    push_item(OP_ALLOC_AT, 100, 10, 3'd6);
    push_item(OP_ALLOC, 0, 5, 3'd4);
    push_item(OP_ALLOC_AT, 110, (64'd1 << 20) - 110, 3'd1);
    push_item(OP_FREE, 0, 0, 3'd0);
    push_item(OP_ALLOC, 0, 1, 3'd2);
    drain();

    // fill the table up until splits are refused
    write_range(0, 66);
    for (int i = 0; i < 64; i++) push_item(OP_ALLOC, 0, 1, 3'($urandom));
    push_item(OP_ALLOC, 0, 3, 3'd1);
    push_item(OP_FREE, 5, 0, 3'd0);
    push_item(OP_ALLOC_AT, 5, 1, 3'd7);
    drain();

    phase_base = '{0, PAGE_SPACE - 1, PAGE_SPACE - 200, 64'($urandom) << 4, 0, 1000,
                   wide_random() & (PAGE_SPACE - 1)};
    phase_len = '{256, PAGE_SPACE, PAGE_SPACE, $urandom_range(64, 600), PAGE_SPACE, 1, 120};
    for (int p = 0; p < 7; p++) begin
      steady = (p % 3 == 2);
      write_range(phase_base[p], phase_len[p]);
      for (int n = 0; n < 185; n++) begin
        while (pending_items.size() >= 2) @(negedge clk);
        push_random();
      end
      drain();
    end

    repeat (20) @(negedge clk);
    $display("covered: ok %0d, no fit %0d, not found %0d, table full %0d results",
             status_seen[STAT_OK], status_seen[STAT_NOFIT], status_seen[STAT_NOTFOUND],
             status_seen[STAT_FULL]);
    $display("nine range settings from a single page to the full page space");
    if (failures == 0 && grants_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
